// ===== design/direct_mapped_cache_tag_lookup_top_macros.svh =====
// Assertion macros used by the checker file of the cache tag lookup.
`ifndef DIRECT_MAPPED_CACHE_TAG_LOOKUP_TOP_MACROS_SVH
`define DIRECT_MAPPED_CACHE_TAG_LOOKUP_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMC_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DMC_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dmc_pkg.sv =====
// Shared types and constants of the direct-mapped cache tag lookup.
`default_nettype none
package dmc_pkg;

	// Fixed field widths.
	localparam int ADDR_W     = 32;
	localparam int TAG_W      = 32;
	localparam int CFG_W      = 4;
	localparam int CNT_W      = 32;
	localparam int LINE_IDX_W = 14;
	localparam int CFG_IDX_W  = 1;

	// Defaults of the top-level parameters.
	localparam int LINES_LOG2_DEF = 14;
	localparam int ADDR_WIDTH_DEF = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 1'b1;

	// Reset values and limits of the configuration registers.
	localparam logic [CFG_W-1:0] OFFSET_RST = 4'd4;
	localparam logic [CFG_W-1:0] INDEX_RST  = 4'd10;
	localparam logic [CFG_W-1:0] OFFSET_MAX = 4'd12;

	// Depth of the queue between front and back end.
	localparam int Q_DEPTH = 2;

	// Queue status seen by both ends.
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_LOOKUP
	} back_state_t;

endpackage
`default_nettype wire

// ===== design/dmc_front.sv =====
// Front end: configuration registers, accept logic and address split.
`default_nettype none
module dmc_front #(
	parameter int LINES_LOG2 = dmc_pkg::LINES_LOG2_DEF,
	parameter int ADDR_WIDTH = dmc_pkg::ADDR_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dmc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dmc_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             start,
	input  logic [dmc_pkg::ADDR_W-1:0]       addr,
	input  logic                             q_full,
	input  logic                             clearing,
	output logic                             busy,
	output logic                             push,
	output logic [LINES_LOG2-1:0]            line,
	output logic [dmc_pkg::TAG_W-1:0]        tag
);

	localparam int AW     = dmc_pkg::ADDR_W;
	localparam int AW_EFF = (ADDR_WIDTH >= AW) ? AW : ADDR_WIDTH;
	localparam logic [AW-1:0] AMASK = {AW{1'b1}} >> (AW - AW_EFF);
	localparam logic [4:0] IDX_CAP = (LINES_LOG2 > 15) ? 5'd15 : 5'(LINES_LOG2);

	logic [dmc_pkg::CFG_W-1:0] offset_bits_q;
	logic [dmc_pkg::CFG_W-1:0] index_bits_q;
	logic [dmc_pkg::CFG_W-1:0] off;
	logic [dmc_pkg::CFG_W-1:0] idx;
	logic [AW-1:0]             a_masked;
	logic [AW-1:0]             shifted;
	logic [LINES_LOG2-1:0]     line_mask;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= dmc_pkg::OFFSET_RST;
			index_bits_q  <= dmc_pkg::INDEX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dmc_pkg::REG_OFFSET_BITS: offset_bits_q <= cfg_wdata;
				dmc_pkg::REG_INDEX_BITS:  index_bits_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// A word is taken when the queue has room and the clearing pass is over.
	assign busy = q_full | clearing;
	assign push = start & ~busy;

	// Saturate the split and cut the address into line and tag.
	always_comb begin
		off       = (offset_bits_q > dmc_pkg::OFFSET_MAX) ? dmc_pkg::OFFSET_MAX : offset_bits_q;
		idx       = ({1'b0, index_bits_q} > IDX_CAP) ? IDX_CAP[3:0] : index_bits_q;
		a_masked  = addr & AMASK;
		shifted   = a_masked >> off;
		line_mask = ~({LINES_LOG2{1'b1}} << idx);
		line      = shifted[LINES_LOG2-1:0] & line_mask;
		tag       = shifted >> idx;
	end

endmodule
`default_nettype wire

// ===== design/dmc_queue.sv =====
// Short word queue between the front end and the back end.
`default_nettype none
module dmc_queue #(
	parameter int DATA_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [DATA_W-1:0]  wdata,
	input  logic               pop,
	output logic [DATA_W-1:0]  rdata,
	output dmc_pkg::q_stat_t   stat
);

	localparam int DEPTH = dmc_pkg::Q_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rdata      = entry_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));

endmodule
`default_nettype wire

// ===== design/dmc_back.sv =====
// Back end: valid and tag arrays, hit check, line fill and running counts.
`default_nettype none
module dmc_back #(
	parameter int LINES_LOG2 = dmc_pkg::LINES_LOG2_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dmc_pkg::q_stat_t                   q_stat,
	input  logic [LINES_LOG2-1:0]              q_line,
	input  logic [dmc_pkg::TAG_W-1:0]          q_tag,
	output logic                               pop,
	output logic                               clearing,
	output logic                               done,
	output logic                               hit,
	output logic [dmc_pkg::LINE_IDX_W-1:0]     line_index,
	output logic [dmc_pkg::CNT_W-1:0]          hit_total,
	output logic [dmc_pkg::CNT_W-1:0]          miss_total
);

	localparam int LINES = 1 << LINES_LOG2;
	localparam int LIW   = dmc_pkg::LINE_IDX_W;

	dmc_pkg::back_state_t state_q, state_d;

	logic                         vld_mem [LINES];
	logic [dmc_pkg::TAG_W-1:0]    tag_mem [LINES];

	logic [LINES_LOG2-1:0]        clr_q;
	logic [LINES_LOG2-1:0]        line_s1;
	logic [dmc_pkg::TAG_W-1:0]    tag_s1;
	logic                         vld_rd_s1;
	logic [dmc_pkg::TAG_W-1:0]    tag_rd_s1;
	logic                         done_q;
	logic                         hit_q;
	logic [LIW-1:0]               line_q;
	logic [dmc_pkg::CNT_W-1:0]    hit_cnt_q;
	logic [dmc_pkg::CNT_W-1:0]    miss_cnt_q;

	logic                         rd_en;
	logic                         vld_we;
	logic                         tag_we;
	logic                         resolve;
	logic                         lookup_hit;
	logic [LINES_LOG2-1:0]        vld_waddr;

	assign lookup_hit = vld_rd_s1 && (tag_rd_s1 == tag_s1);
	assign clearing   = (state_q == dmc_pkg::BK_CLEAR);
	assign vld_waddr  = clearing ? clr_q : line_s1;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmc_pkg::BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes: clear the valid array, then read, then resolve.
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		rd_en   = 1'b0;
		vld_we  = 1'b0;
		tag_we  = 1'b0;
		resolve = 1'b0;
		case (state_q)
			dmc_pkg::BK_CLEAR: begin
				vld_we = 1'b1;
				if (clr_q == {LINES_LOG2{1'b1}}) begin
					state_d = dmc_pkg::BK_IDLE;
				end
			end
			dmc_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					rd_en   = 1'b1;
					state_d = dmc_pkg::BK_LOOKUP;
				end
			end
			dmc_pkg::BK_LOOKUP: begin
				resolve = 1'b1;
				vld_we  = ~lookup_hit;
				tag_we  = ~lookup_hit;
				state_d = dmc_pkg::BK_IDLE;
			end
			default: begin
				state_d = dmc_pkg::BK_IDLE;
			end
		endcase
	end

	// Valid array with registered read; cleared entry by entry after reset.
	always_ff @(posedge clk) begin
		if (vld_we) begin
			vld_mem[vld_waddr] <= ~clearing;
		end
		if (rd_en) begin
			vld_rd_s1 <= vld_mem[q_line];
		end
	end

	// Tag array with registered read.
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[line_s1] <= tag_s1;
		end
		if (rd_en) begin
			tag_rd_s1 <= tag_mem[q_line];
		end
	end

	// Word under lookup.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			line_s1 <= q_line;
			tag_s1  <= q_tag;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (resolve) begin
			hit_q  <= lookup_hit;
			line_q <= LIW'(line_s1);
		end
	end

	// Clearing sweep, result strobe and running counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			done_q     <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else begin
			done_q <= resolve;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (resolve && lookup_hit) begin
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end
			if (resolve && !lookup_hit) begin
				miss_cnt_q <= miss_cnt_q + 1'b1;
			end
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign line_index = line_q;
	assign hit_total  = hit_cnt_q;
	assign miss_total = miss_cnt_q;

endmodule
`default_nettype wire

// ===== design/direct_mapped_cache_tag_lookup_top.sv =====
// Top level of the direct-mapped cache tag lookup.
//
//   channel   handshake              payload
//   config    cfg_we                 cfg_index, cfg_wdata
//   access    start high, busy low   addr
//   result    done (one cycle)       hit, line_index, hit_total, miss_total
//
// The back end handles each word in two states: BK_IDLE reads the valid and
// tag arrays, BK_LOOKUP compares, fills the line on a miss and updates the counts.
// A word passes the queue entry, the array read registers and the result registers.
// After reset busy stays high while the valid array
// is cleared one entry per cycle; configuration writes are taken meanwhile.
// busy also rises while the two-entry queue is full; results are never held.
`default_nettype none
module direct_mapped_cache_tag_lookup_top #(
	parameter int LINES_LOG2 = dmc_pkg::LINES_LOG2_DEF,
	parameter int ADDR_WIDTH = dmc_pkg::ADDR_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dmc_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                               start,
	input  logic [dmc_pkg::ADDR_W-1:0]         addr,
	output logic                               busy,
	output logic                               done,
	output logic                               hit,
	output logic [dmc_pkg::LINE_IDX_W-1:0]     line_index,
	output logic [dmc_pkg::CNT_W-1:0]          hit_total,
	output logic [dmc_pkg::CNT_W-1:0]          miss_total
);

	localparam int QW = dmc_pkg::TAG_W + LINES_LOG2;

	logic                         push;
	logic                         pop;
	logic                         clearing;
	logic [LINES_LOG2-1:0]        f_line;
	logic [dmc_pkg::TAG_W-1:0]    f_tag;
	logic [QW-1:0]                q_rdata;
	dmc_pkg::q_stat_t             q_stat;

	// Accept and split.
	dmc_front #(
		.LINES_LOG2 (LINES_LOG2),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.addr      (addr),
		.q_full    (q_stat.full),
		.clearing  (clearing),
		.busy      (busy),
		.push      (push),
		.line      (f_line),
		.tag       (f_tag)
	);

	// Decoupling queue.
	dmc_queue #(
		.DATA_W (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_tag, f_line}),
		.pop    (pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	// Lookup and update.
	dmc_back #(
		.LINES_LOG2 (LINES_LOG2)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.q_line     (q_rdata[LINES_LOG2-1:0]),
		.q_tag      (q_rdata[QW-1:LINES_LOG2]),
		.pop        (pop),
		.clearing   (clearing),
		.done       (done),
		.hit        (hit),
		.line_index (line_index),
		.hit_total  (hit_total),
		.miss_total (miss_total)
	);

endmodule
`default_nettype wire

// ===== design/dmc_checker.sv =====
// Port-level checker of the cache tag lookup and its bind to the top level.
`default_nettype none
`include "direct_mapped_cache_tag_lookup_top_macros.svh"
module dmc_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               done,
	input  logic                               hit,
	input  logic [dmc_pkg::CNT_W-1:0]          hit_total,
	input  logic [dmc_pkg::CNT_W-1:0]          miss_total
);

	// Each result adds exactly one to the sum of both counts.
	`DMC_ASSERT_IMP(a_count_step, clk, arst_n, done, (hit_total + miss_total) == ($past(hit_total) + $past(miss_total) + 32'd1), "result did not advance the counts by one")

	// The counts only move with a result.
	`DMC_ASSERT_IMP(a_count_hold, clk, arst_n, !done, $stable(hit_total) && $stable(miss_total), "counts moved without a result")

	// A hit advances the hit count, a miss the miss count.
	`DMC_ASSERT_IMP(a_count_kind, clk, arst_n, done, hit ? (hit_total != $past(hit_total)) : (miss_total != $past(miss_total)), "wrong count advanced")

	// A result strobe is never directly followed by another.
	`DMC_ASSERT_NXT(a_done_gap, clk, arst_n, done, !done, "results in back-to-back cycles")

endmodule

bind direct_mapped_cache_tag_lookup_top dmc_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.done       (done),
	.hit        (hit),
	.hit_total  (hit_total),
	.miss_total (miss_total)
);
`default_nettype wire
